/* design/sfr_pkg.sv */
package sfr_pkg;

  // Store and word sizes.
  localparam int STORE_DEPTH    = 32;
  localparam int MAX_WORD_BYTES = 4;
  // Bytes past the fourth of a word fall outside the 32-bit element.
  localparam int WORD_LANES     = (MAX_WORD_BYTES < 4) ? MAX_WORD_BYTES : 4;
  localparam int NUM_REGS       = 8;
  localparam int REG_IDX_W      = 3;

  // Frame position: three header slots below zero, data slots from zero up.
  localparam int POS_W = 9;
  localparam logic signed [POS_W-1:0] POS_START = -9'sd3;
  localparam logic signed [POS_W-1:0] POS_SIZE  = -9'sd2;
  localparam logic signed [POS_W-1:0] POS_ONE   = 9'sd1;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ACK      = 3'd0,
    REG_RANGING  = 3'd1,
    REG_HEADING  = 3'd2,
    REG_STATUS   = 3'd3,
    REG_STOP     = 3'd4,
    REG_CHAR     = 3'd5,
    REG_INT      = 3'd6,
    REG_FLOAT    = 3'd7
  } reg_idx_t;

  localparam logic [7:0] REG_RESET [NUM_REGS] =
    '{8'd6, 8'd161, 8'd162, 8'd163, 8'd175, 8'd0, 8'd1, 8'd2};

  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_ABORT = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_RANGING = 2'd0,
    CMD_HEADING = 2'd1,
    CMD_STATE   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2,
    ST_DROP = 2'd3
  } status_t;

  // Link flags seen after an item.
  typedef struct packed {
    logic receiving;
    logic ack_seen;
    logic ack_confirmed;
    logic online;
  } flags_t;

  // Request to the element sequencer when a frame completes.
  typedef struct packed {
    logic       start;
    logic       is_int;
    logic [7:0] size;
    cmd_t       cmd;
  } emit_cmd_t;

  // One payload element from the sequencer.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] value;
    logic [4:0]  index;
    logic        last;
  } elem_t;

endpackage

/* design/sfr_ram.sv */
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/sfr_ctrl.sv */
module sfr_ctrl
  import sfr_pkg::*;
#(
  parameter int STORE_DEPTH = sfr_pkg::STORE_DEPTH,
  localparam int AW = $clog2(STORE_DEPTH),
  localparam int ST_W = $clog2(STORE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [1:0]           mode,
  input  logic [7:0]           byte_value,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [7:0]           ram_wdata,
  output logic                 status_valid,
  output cmd_t                 status_cmd,
  output status_t              status_code,
  output flags_t               flags,
  output emit_cmd_t            emit_cmd,
  output logic [ST_W-1:0]      emit_stored
);

  localparam logic [8:0] DEPTH_9 = 9'(STORE_DEPTH);

  logic [7:0] cfg_reg [NUM_REGS];

  logic                    in_frame, in_frame_next;
  logic signed [POS_W-1:0] position, position_next;
  logic [7:0]              payload_type, payload_type_next;
  logic [7:0]              element_size, element_size_next;
  logic [7:0]              byte_count, byte_count_next;
  cmd_t                    frame_kind, frame_kind_next;
  logic                    ack_first, ack_first_next;
  logic                    ack_second, ack_second_next;
  logic                    link_up, link_up_next;

  logic    complete;
  logic    show_kind;
  logic    header_bad;
  status_t status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_reg[i] <= REG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  assign header_bad = (payload_type != cfg_reg[REG_CHAR] &&
                       payload_type != cfg_reg[REG_INT] &&
                       payload_type != cfg_reg[REG_FLOAT]) ||
                      element_size == 8'd0 || byte_count == 8'd0;

  // Receive state update for one item.
  always_comb begin
    in_frame_next     = in_frame;
    position_next     = position;
    payload_type_next = payload_type;
    element_size_next = element_size;
    byte_count_next   = byte_count;
    frame_kind_next   = frame_kind;
    ack_first_next    = ack_first;
    ack_second_next   = ack_second;
    link_up_next      = link_up;
    complete          = 1'b0;
    show_kind         = 1'b0;
    status            = ST_NONE;
    ram_we            = 1'b0;
    if (fire) begin
      unique case (mode_t'(mode))
        MODE_CLEAR: begin
          ack_first_next  = 1'b0;
          ack_second_next = 1'b0;
        end
        MODE_ABORT: begin
          in_frame_next     = 1'b0;
          position_next     = POS_START;
          element_size_next = 8'd0;
        end
        MODE_BYTE: begin
          link_up_next = 1'b1;
          if (!in_frame) begin
            if (byte_value == 8'd0) begin
              // A zero byte between frames is line noise.
            end else if (byte_value == cfg_reg[REG_ACK]) begin
              if (ack_first) begin
                ack_second_next = 1'b1;
              end else begin
                ack_first_next = 1'b1;
              end
            end else if (byte_value == cfg_reg[REG_RANGING]) begin
              in_frame_next   = 1'b1;
              frame_kind_next = CMD_RANGING;
            end else if (byte_value == cfg_reg[REG_HEADING]) begin
              in_frame_next   = 1'b1;
              frame_kind_next = CMD_HEADING;
            end else if (byte_value == cfg_reg[REG_STATUS]) begin
              in_frame_next   = 1'b1;
              frame_kind_next = CMD_STATE;
            end
          end else if (position[POS_W-1]) begin
            // Header bytes: type, element size, byte count.
            if (position == POS_START) begin
              payload_type_next = byte_value;
            end else if (position == POS_SIZE) begin
              element_size_next = byte_value;
            end else begin
              byte_count_next = byte_value;
            end
            position_next = position + POS_ONE;
          end else if (header_bad) begin
            in_frame_next     = 1'b0;
            position_next     = POS_START;
            element_size_next = 8'd0;
            status            = ST_BAD;
            show_kind         = 1'b1;
          end else if (position[7:0] >= byte_count && byte_value == cfg_reg[REG_STOP]) begin
            complete          = 1'b1;
            in_frame_next     = 1'b0;
            position_next     = POS_START;
            element_size_next = 8'd0;
          end else begin
            if ({1'b0, position[7:0]} < DEPTH_9) begin
              ram_we = 1'b1;
            end else begin
              status = ST_DROP;
            end
            if (position[7:0] != 8'hFF) begin
              position_next = position + POS_ONE;
            end
          end
        end
        MODE_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      position     <= POS_START;
      payload_type <= REG_RESET[REG_CHAR];
      element_size <= 8'd0;
      byte_count   <= 8'd0;
      frame_kind   <= CMD_RANGING;
      ack_first    <= 1'b0;
      ack_second   <= 1'b0;
      link_up      <= 1'b0;
    end else begin
      in_frame     <= in_frame_next;
      position     <= position_next;
      payload_type <= payload_type_next;
      element_size <= element_size_next;
      byte_count   <= byte_count_next;
      frame_kind   <= frame_kind_next;
      ack_first    <= ack_first_next;
      ack_second   <= ack_second_next;
      link_up      <= link_up_next;
    end
  end

  assign ram_waddr = position[AW-1:0];
  assign ram_wdata = byte_value;

  // Status transaction for every item that does not complete a frame.
  assign status_valid = fire && !complete;
  assign status_cmd   = (in_frame_next || show_kind) ? frame_kind_next : CMD_NONE;
  assign status_code  = status;

  assign flags.receiving     = in_frame_next;
  assign flags.ack_seen      = ack_first_next;
  assign flags.ack_confirmed = ack_second_next;
  assign flags.online        = link_up_next;

  // Completion request, with the header values taken before they clear.
  assign emit_cmd.start  = fire && complete;
  assign emit_cmd.is_int = (payload_type == cfg_reg[REG_INT]);
  assign emit_cmd.size   = element_size;
  assign emit_cmd.cmd    = frame_kind;
  assign emit_stored     = ({1'b0, byte_count} < DEPTH_9) ? byte_count[ST_W-1:0]
                                                          : ST_W'(STORE_DEPTH);

  // Outside a frame the position always sits at the first header slot.
  a_idle_position: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (position == POS_START && element_size == 8'd0))
    else $error("position or element size not cleared outside a frame");

endmodule

/* design/sfr_emit.sv */
module sfr_emit
  import sfr_pkg::*;
#(
  parameter int STORE_DEPTH = sfr_pkg::STORE_DEPTH,
  localparam int AW = $clog2(STORE_DEPTH),
  localparam int ST_W = $clog2(STORE_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  emit_cmd_t       emit_cmd,
  input  logic [ST_W-1:0] emit_stored,
  input  logic            slot_free,
  output logic [AW-1:0]   ram_raddr,
  input  logic [7:0]      ram_rdata,
  output logic            busy,
  output logic            elem_valid,
  output elem_t           elem,
  output logic            free_bit,
  output logic            barrier_bit
);

  localparam int SUM_W = ((ST_W > 8) ? ST_W : 8) + 1;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_READ = 4'b0010,
    E_ACC  = 4'b0100,
    E_PUT  = 4'b1000
  } emit_state_t;

  emit_state_t state, state_next;

  logic [AW-1:0]   base;
  logic [1:0]      lane;
  logic [4:0]      index;
  logic [31:0]     acc;
  logic [ST_W-1:0] stored;
  logic [7:0]      step;
  logic [2:0]      nb;
  cmd_t            cmd;

  logic [SUM_W-1:0] byte_at;
  logic [SUM_W-1:0] base_step;
  logic             more_bytes;
  logic             last_word;

  // Address of the byte under work and the checks that move the sequencer on.
  assign byte_at    = SUM_W'(base) + SUM_W'(lane);
  assign base_step  = SUM_W'(base) + SUM_W'(step);
  assign more_bytes = (3'(lane) + 3'd1 < nb) && (byte_at + SUM_W'(1) < SUM_W'(stored));
  assign last_word  = (&index) || (base_step >= SUM_W'(stored));
  assign ram_raddr  = AW'(byte_at);

  always_comb begin
    state_next = state;
    unique case (state)
      E_IDLE: if (emit_cmd.start) state_next = E_READ;
      E_READ: state_next = E_ACC;
      E_ACC:  state_next = more_bytes ? E_READ : E_PUT;
      E_PUT: begin
        if (slot_free) begin
          state_next = last_word ? E_IDLE : E_READ;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= E_IDLE;
      free_bit    <= 1'b0;
      barrier_bit <= 1'b0;
    end else begin
      state <= state_next;
      // The state frame reports the two low bits of its first byte.
      if (state == E_ACC && byte_at == SUM_W'(0) && cmd == CMD_STATE) begin
        free_bit    <= ram_rdata[0];
        barrier_bit <= ram_rdata[1];
      end
    end
  end

  // Word assembly: one byte lane filled per read.
  always_ff @(posedge clk) begin
    unique case (state)
      E_IDLE: begin
        if (emit_cmd.start) begin
          base   <= '0;
          lane   <= 2'd0;
          index  <= 5'd0;
          acc    <= 32'd0;
          stored <= emit_stored;
          cmd    <= emit_cmd.cmd;
          if (emit_cmd.is_int) begin
            step <= emit_cmd.size;
            nb   <= (emit_cmd.size < 8'(WORD_LANES)) ? emit_cmd.size[2:0] : 3'(WORD_LANES);
          end else begin
            step <= 8'd1;
            nb   <= 3'd1;
          end
        end
      end
      E_READ: begin
      end
      E_ACC: begin
        acc[{lane, 3'b000} +: 8] <= ram_rdata;
        if (more_bytes) begin
          lane <= lane + 2'd1;
        end
      end
      E_PUT: begin
        if (slot_free && !last_word) begin
          base  <= AW'(base_step);
          lane  <= 2'd0;
          index <= index + 5'd1;
          acc   <= 32'd0;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy       = (state != E_IDLE);
  assign elem_valid = (state == E_PUT) && slot_free;
  assign elem.cmd   = cmd;
  assign elem.value = acc;
  assign elem.index = index;
  assign elem.last  = last_word;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    emit_cmd.start |-> state == E_IDLE)
    else $error("frame completion while elements still being sent");

  a_read_in_store: assert property (@(posedge clk) disable iff (rst)
    state == E_READ |-> byte_at < SUM_W'(stored))
    else $error("read beyond the stored bytes");

  a_lane_in_word: assert property (@(posedge clk) disable iff (rst)
    state == E_ACC |-> 3'(lane) < nb)
    else $error("byte lane beyond word size");

endmodule

/* design/serial_frame_receiver.sv */
// Channel  Direction  Signals                                   Content
// s_*      in         s_tvalid s_tready s_tdata s_tuser         one item: byte or request
// m_*      out        m_tvalid m_tready m_tdata m_tuser m_tlast one status or payload element
// cfg_*    in         cfg_valid cfg_ready cfg_index cfg_data    register write
//
// A status item's result is registered at the edge that accepts it.
// A completing stop byte sends min(elements, 32) results through one shared byte reader:
// each stored byte is read through the E_READ and E_ACC states and each element leaves
// from E_PUT; a raw element reads one byte and an int word at most min(size, 4), fewer where
// the stored bytes end inside it; s_tready stays low until the last one leaves.
// Reset is synchronous; the byte store is not cleared and needs no clearing pass.
// While a result waits with m_tready low, the result register holds and no new item
// is taken.
module serial_frame_receiver
  import sfr_pkg::*;
#(
  parameter int STORE_DEPTH = sfr_pkg::STORE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,    // [7:0] byte_value
  input  logic [1:0]           s_tuser,    // [1:0] mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,    // [1:0] frame_command, [33:2] element_value,
                                           // [38:34] element_index, [39] receiving,
                                           // [40] ack_seen, [41] ack_confirmed,
                                           // [42] free_flag, [43] barrier_flag,
                                           // [45:44] frame_status, [46] online, [47] zero
  output logic [0:0]           m_tuser,    // [0] result_kind
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int ST_W = $clog2(STORE_DEPTH + 1);

  logic            fire;
  logic            slot_free;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  logic            status_valid;
  cmd_t            status_cmd;
  status_t         status_code;
  flags_t          flags;
  emit_cmd_t       emit_cmd;
  logic [ST_W-1:0] emit_stored;
  logic            busy;
  logic            elem_valid;
  elem_t           elem;
  logic            free_bit;
  logic            barrier_bit;

  // Result register.
  logic        out_kind;
  cmd_t        out_cmd;
  logic [31:0] out_value;
  logic [4:0]  out_index;
  logic        out_last;
  flags_t      out_flags;
  logic        out_free;
  logic        out_barrier;
  status_t     out_status;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = !busy && slot_free;
  assign fire      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  sfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sfr_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .mode         (s_tuser),
    .byte_value   (s_tdata),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .status_valid (status_valid),
    .status_cmd   (status_cmd),
    .status_code  (status_code),
    .flags        (flags),
    .emit_cmd     (emit_cmd),
    .emit_stored  (emit_stored)
  );

  sfr_emit #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .emit_cmd    (emit_cmd),
    .emit_stored (emit_stored),
    .slot_free   (slot_free),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .busy        (busy),
    .elem_valid  (elem_valid),
    .elem        (elem),
    .free_bit    (free_bit),
    .barrier_bit (barrier_bit)
  );

  // Output valid: loaded by a status or an element, cleared once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (status_valid || elem_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status_valid) begin
      out_kind    <= 1'b0;
      out_cmd     <= status_cmd;
      out_value   <= 32'd0;
      out_index   <= 5'd0;
      out_last    <= 1'b1;
      out_flags   <= flags;
      out_free    <= free_bit;
      out_barrier <= barrier_bit;
      out_status  <= status_code;
    end else if (elem_valid) begin
      out_kind    <= 1'b1;
      out_cmd     <= elem.cmd;
      out_value   <= elem.value;
      out_index   <= elem.index;
      out_last    <= elem.last;
      out_flags   <= flags;
      out_free    <= free_bit;
      out_barrier <= barrier_bit;
      out_status  <= ST_DONE;
    end
  end

  assign m_tdata = {1'b0, out_flags.online, out_status, out_barrier, out_free,
                    out_flags.ack_confirmed, out_flags.ack_seen, out_flags.receiving,
                    out_index, out_value, out_cmd};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(status_valid && elem_valid))
    else $error("status and element loaded into the result register together");

  a_elem_not_receiving: assert property (@(posedge clk) disable iff (rst)
    elem_valid |-> !flags.receiving)
    else $error("element sent while a new frame is open");

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int POS_LIMIT   = 255;
  localparam int MAX_ELEMS   = 32;
  localparam int HOLD_CYCLES = 300;

  // Register settings by index: two corner sets with overlapping codes.
  localparam logic [7:0] CFG_CORNER_A [NUM_REGS] =
    '{8'd255, 8'd0, 8'd1, 8'd254, 8'd0, 8'd255, 8'd0, 8'd128};
  localparam logic [7:0] CFG_CORNER_B [NUM_REGS] =
    '{8'd1, 8'd255, 8'd255, 8'd128, 8'd255, 8'd0, 8'd0, 8'd255};

  // One result as the block presents it.
  typedef struct packed {
    logic        kind;
    cmd_t        cmd;
    logic [31:0] value;
    logic [4:0]  index;
    logic        tail;
    logic        recv;
    logic        ack_s;
    logic        ack_c;
    logic        free_f;
    logic        barrier_f;
    status_t     status;
    logic        online;
  } rx_result_t;

  // One row of the directed stimulus; pinned rows carry a typed-in outcome.
  typedef struct {
    mode_t      mode;
    logic [7:0] data;
    bit         pinned;
    cmd_t       cmd;
    status_t    status;
    logic       recv;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{MODE_BYTE,  8'h00, 1'b1, CMD_NONE,    ST_NONE, 1'b0},  // zero byte ignored
    '{MODE_BYTE,  8'h06, 1'b1, CMD_NONE,    ST_NONE, 1'b0},  // first ack
    '{MODE_BYTE,  8'h06, 1'b1, CMD_NONE,    ST_NONE, 1'b0},  // second ack
    '{MODE_CLEAR, 8'hFF, 1'b1, CMD_NONE,    ST_NONE, 1'b0},
    '{MODE_NOP,   8'hAA, 1'b1, CMD_NONE,    ST_NONE, 1'b0},
    '{MODE_BYTE,  8'hA3, 1'b1, CMD_STATE,   ST_NONE, 1'b1},  // state frame opens
    '{MODE_BYTE,  8'h00, 1'b0, CMD_NONE,    ST_NONE, 1'b0},  // char type
    '{MODE_BYTE,  8'h01, 1'b0, CMD_NONE,    ST_NONE, 1'b0},
    '{MODE_BYTE,  8'h02, 1'b0, CMD_NONE,    ST_NONE, 1'b0},
    '{MODE_BYTE,  8'h03, 1'b0, CMD_NONE,    ST_NONE, 1'b0},  // free and barrier bits
    '{MODE_BYTE,  8'hAF, 1'b0, CMD_NONE,    ST_NONE, 1'b0},  // stop code kept as data
    '{MODE_BYTE,  8'hAF, 1'b0, CMD_NONE,    ST_NONE, 1'b0},  // completes
    '{MODE_BYTE,  8'hA1, 1'b1, CMD_RANGING, ST_NONE, 1'b1},
    '{MODE_BYTE,  8'hFF, 1'b0, CMD_NONE,    ST_NONE, 1'b0},  // unknown type
    '{MODE_BYTE,  8'h01, 1'b0, CMD_NONE,    ST_NONE, 1'b0},
    '{MODE_BYTE,  8'h01, 1'b0, CMD_NONE,    ST_NONE, 1'b0},
    '{MODE_BYTE,  8'h55, 1'b1, CMD_RANGING, ST_BAD,  1'b0},  // header rejected
    '{MODE_BYTE,  8'hA2, 1'b1, CMD_HEADING, ST_NONE, 1'b1},
    '{MODE_BYTE,  8'h01, 1'b0, CMD_NONE,    ST_NONE, 1'b0},  // int type
    '{MODE_BYTE,  8'hFF, 1'b0, CMD_NONE,    ST_NONE, 1'b0},  // widest element
    '{MODE_BYTE,  8'h03, 1'b0, CMD_NONE,    ST_NONE, 1'b0},
    '{MODE_BYTE,  8'h11, 1'b0, CMD_NONE,    ST_NONE, 1'b0},
    '{MODE_BYTE,  8'h22, 1'b0, CMD_NONE,    ST_NONE, 1'b0},
    '{MODE_BYTE,  8'h80, 1'b0, CMD_NONE,    ST_NONE, 1'b0},
    '{MODE_BYTE,  8'hAF, 1'b0, CMD_NONE,    ST_NONE, 1'b0}   // word with a missing byte
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;    // [7:0] byte_value
  logic [1:0]           s_tuser;    // [1:0] mode
  logic                 m_tvalid;
  logic                 m_tready;
  logic [47:0]          m_tdata;    // [1:0] frame_command, [33:2] element_value,
                                    // [38:34] element_index, [39] receiving,
                                    // [40] ack_seen, [41] ack_confirmed,
                                    // [42] free_flag, [43] barrier_flag,
                                    // [45:44] frame_status, [46] online, [47] zero
  logic [0:0]           m_tuser;    // [0] result_kind
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  // Receiver model state, reset values included.
  logic [7:0] cfg_regs [NUM_REGS] = REG_RESET;
  logic       rx_active = 1'b0;
  int         rx_pos = int'(POS_START);
  logic [7:0] rx_type = REG_RESET[REG_CHAR];
  logic [7:0] rx_size = 8'd0;
  logic [7:0] rx_count = 8'd0;
  cmd_t       rx_cmd = CMD_RANGING;
  logic [7:0] rx_store [STORE_DEPTH] = '{default: 8'd0};
  logic       ack_a = 1'b0;
  logic       ack_b = 1'b0;
  logic       link_r = 1'b0;
  logic       free_r = 1'b0;
  logic       barrier_r = 1'b0;

  rx_result_t expected_q [$];
  int         errors = 0;
  int         cycle_cnt = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         hold_left = 0;

  serial_frame_receiver i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1ns clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Queue one result built from the flags as they stand now.
  task automatic push_result(input logic kind, input cmd_t cmd, input logic [31:0] value,
                             input logic [4:0] index, input logic tail,
                             input status_t status);
    rx_result_t r;
    r.kind      = kind;
    r.cmd       = cmd;
    r.value     = value;
    r.index     = index;
    r.tail      = tail;
    r.recv      = rx_active;
    r.ack_s     = ack_a;
    r.ack_c     = ack_b;
    r.free_f    = free_r;
    r.barrier_f = barrier_r;
    r.status    = status;
    r.online    = link_r;
    expected_q.push_back(r);
  endtask

  task automatic drop_frame();
    rx_active = 1'b0;
    rx_pos    = int'(POS_START);
    rx_size   = 8'd0;
  endtask

  // A stop byte after the full count: emit the payload elements.
  task automatic finish_frame();
    int          stored;
    int          count;
    int          size;
    int          nb;
    int          at;
    logic        is_int;
    logic [31:0] word;
    cmd_t        cmd;
    stored = (int'(rx_count) < STORE_DEPTH) ? int'(rx_count) : STORE_DEPTH;
    cmd    = rx_cmd;
    size   = int'(rx_size);
    is_int = (rx_type == cfg_regs[REG_INT]);
    if (cmd == CMD_STATE) begin
      free_r    = rx_store[0][0];
      barrier_r = rx_store[0][1];
    end
    count = is_int ? (stored + size - 1) / size : stored;
    if (count > MAX_ELEMS) count = MAX_ELEMS;
    drop_frame();
    if (count == 0) begin
      push_result(1'b0, cmd, 32'd0, 5'd0, 1'b1, ST_DONE);
      return;
    end
    nb = (size < MAX_WORD_BYTES) ? size : MAX_WORD_BYTES;
    for (int k = 0; k < count; k++) begin
      if (is_int) begin
        word = '0;
        for (int i = 0; i < nb; i++) begin
          at = k * size + i;
          if (at < stored) word |= 32'(rx_store[at]) << (8 * i);
        end
      end else begin
        word = 32'(rx_store[k]);
      end
      push_result(1'b1, cmd, word, k[4:0], (k + 1 == count), ST_DONE);
    end
  endtask

  // Advance the receiver model by one accepted item.
  task automatic predict_item(input mode_t mode, input logic [7:0] b);
    status_t st;
    logic    show;
    cmd_t    shown;
    st   = ST_NONE;
    show = 1'b0;
    case (mode)
      MODE_CLEAR: begin
        ack_a = 1'b0;
        ack_b = 1'b0;
      end
      MODE_ABORT: drop_frame();
      MODE_BYTE: begin
        link_r = 1'b1;
        if (!rx_active) begin
          if (b == 8'd0) begin
            // Idle zero bytes do nothing.
          end else if (b == cfg_regs[REG_ACK]) begin
            if (ack_a) ack_b = 1'b1;
            else ack_a = 1'b1;
          end else if (b == cfg_regs[REG_RANGING]) begin
            rx_active = 1'b1;
            rx_cmd    = CMD_RANGING;
          end else if (b == cfg_regs[REG_HEADING]) begin
            rx_active = 1'b1;
            rx_cmd    = CMD_HEADING;
          end else if (b == cfg_regs[REG_STATUS]) begin
            rx_active = 1'b1;
            rx_cmd    = CMD_STATE;
          end
        end else if (rx_pos < 0) begin
          if (rx_pos == int'(POS_START)) rx_type = b;
          else if (rx_pos == int'(POS_SIZE)) rx_size = b;
          else rx_count = b;
          rx_pos++;
        end else if ((rx_type != cfg_regs[REG_CHAR] && rx_type != cfg_regs[REG_INT] &&
                      rx_type != cfg_regs[REG_FLOAT]) || rx_size == 8'd0 ||
                     rx_count == 8'd0) begin
          drop_frame();
          st   = ST_BAD;
          show = 1'b1;
        end else if (rx_pos >= int'(rx_count) && b == cfg_regs[REG_STOP]) begin
          finish_frame();
          return;
        end else begin
          if (rx_pos < STORE_DEPTH) rx_store[rx_pos] = b;
          else st = ST_DROP;
          if (rx_pos < POS_LIMIT) rx_pos++;
        end
      end
      default: ;
    endcase
    shown = (rx_active || show) ? rx_cmd : CMD_NONE;
    push_result(1'b0, shown, 32'd0, 5'd0, 1'b1, st);
  endtask

  // Offer one item in bursts with random gaps; called and left at a falling edge.
  task automatic send_item(input mode_t mode, input logic [7:0] data,
                           input bit pinned = 1'b0, input cmd_t pin_cmd = CMD_NONE,
                           input status_t pin_status = ST_NONE,
                           input logic pin_recv = 1'b0);
    int         gap;
    rx_result_t r;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(0, 255));
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    predict_item(mode, data);
    if (pinned) begin
      r = expected_q.pop_back();
      r.cmd    = pin_cmd;
      r.status = pin_status;
      r.recv   = pin_recv;
      expected_q.push_back(r);
    end
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Stop offering, let every pending result drain, and let the bench settle.
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all registers back to back, valid held high across the writes.
  task automatic program_regs(input logic [7:0] vals [NUM_REGS]);
    reg_idx_t r;
    r = REG_ACK;
    repeat (NUM_REGS) begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      cfg_regs[r] = vals[r];
      @(negedge clk);
      r = r.next();
    end
    cfg_valid <= 1'b0;
  endtask

  // Isolated bytes and requests outside of well-formed frames.
  task automatic send_noise();
    case ($urandom_range(0, 7))
      0: send_item(MODE_BYTE, 8'd0);
      1: send_item(MODE_BYTE, cfg_regs[REG_ACK]);
      2: send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
      3: send_item(MODE_ABORT, 8'($urandom_range(0, 255)));
      4: send_item(MODE_NOP, 8'($urandom_range(0, 255)));
      5: send_item(MODE_BYTE, cfg_regs[REG_STOP]);
      default: send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
    endcase
  endtask

  // A frame that is mostly well formed, with a bad header or abort now and then.
  task automatic send_frame();
    logic [7:0] ptype;
    logic [7:0] esize;
    logic [7:0] bcount;
    int         ndata;
    int         roll;
    case ($urandom_range(0, 2))
      0: send_item(MODE_BYTE, cfg_regs[REG_RANGING]);
      1: send_item(MODE_BYTE, cfg_regs[REG_HEADING]);
      default: send_item(MODE_BYTE, cfg_regs[REG_STATUS]);
    endcase
    roll = $urandom_range(0, 9);
    if (roll < 3) ptype = cfg_regs[REG_CHAR];
    else if (roll < 6) ptype = cfg_regs[REG_INT];
    else if (roll < 8) ptype = cfg_regs[REG_FLOAT];
    else ptype = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 9);
    if (roll < 7) esize = 8'($urandom_range(1, 6));
    else if (roll < 8) esize = 8'd0;
    else esize = 8'($urandom_range(7, 255));
    roll = $urandom_range(0, 9);
    if (roll < 6) bcount = 8'($urandom_range(1, 10));
    else if (roll < 7) bcount = 8'd0;
    else if (roll < 8) bcount = 8'($urandom_range(11, 31));
    else bcount = 8'($urandom_range(32, 40));
    send_item(MODE_BYTE, ptype);
    send_item(MODE_BYTE, esize);
    send_item(MODE_BYTE, bcount);
    ndata = int'(bcount) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    if (ndata == 0) ndata = 1;
    for (int i = 0; i < ndata; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        send_item(MODE_ABORT, 8'($urandom_range(0, 255)));
        return;
      end
      send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
    end
    send_item(MODE_BYTE, cfg_regs[REG_STOP]);
  endtask

  // Full-count int frame that runs past the end of the byte store.
  task automatic send_long_frame();
    send_item(MODE_BYTE, cfg_regs[REG_HEADING]);
    send_item(MODE_BYTE, cfg_regs[REG_INT]);
    send_item(MODE_BYTE, 8'($urandom_range(1, 4)));
    send_item(MODE_BYTE, 8'(STORE_DEPTH + 2));
    repeat (STORE_DEPTH + 2) send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
    send_item(MODE_BYTE, cfg_regs[REG_STOP]);
  endtask

  task automatic run_random(input int n_items, input bit with_hold);
    int  first;
    bit  hold_due;
    first    = items_sent;
    hold_due = with_hold;
    while (items_sent - first < n_items) begin
      if (hold_due && items_sent - first > n_items / 2) begin
        hold_left = HOLD_CYCLES;
        hold_due  = 1'b0;
      end
      if ($urandom_range(0, 9) < 7) send_frame();
      else send_noise();
    end
  endtask

  // Receiver readiness: a long hold-off when asked, otherwise rotating stall patterns.
  initial begin
    logic [15:0] pat;
    logic [3:0]  pat_ph;
    int          pat_left;
    pat      = '1;
    pat_ph   = '0;
    pat_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        if (pat_left == 0) begin
          case ($urandom_range(0, 3))
            0: pat = '1;
            1: pat = 16'h5555;
            default: pat = 16'($urandom_range(0, 16'hFFFF)) | 16'h0001;
          endcase
          pat_left = $urandom_range(20, 80);
        end
        m_tready <= pat[pat_ph];
        pat_ph++;
        pat_left--;
      end
    end
  end

  // Compare every result transaction against the oldest expectation.
  always @(posedge clk) begin
    rx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: kind %0d data %0h",
                         m_tuser[0], m_tdata));
      end else begin
        want = expected_q.pop_front();
        check_field("result_kind", 32'(m_tuser[0]), 32'(want.kind));
        check_field("frame_command", 32'(m_tdata[1:0]), 32'(want.cmd));
        check_field("element_value", m_tdata[33:2], want.value);
        check_field("element_index", 32'(m_tdata[38:34]), 32'(want.index));
        check_field("last", 32'(m_tlast), 32'(want.tail));
        check_field("receiving", 32'(m_tdata[39]), 32'(want.recv));
        check_field("ack_seen", 32'(m_tdata[40]), 32'(want.ack_s));
        check_field("ack_confirmed", 32'(m_tdata[41]), 32'(want.ack_c));
        check_field("free_flag", 32'(m_tdata[42]), 32'(want.free_f));
        check_field("barrier_flag", 32'(m_tdata[43]), 32'(want.barrier_f));
        check_field("frame_status", 32'(m_tdata[45:44]), 32'(want.status));
        check_field("online", 32'(m_tdata[46]), 32'(want.online));
      end
    end
  end

  // Main sequence: directed rows, then random phases under several settings.
  initial begin
    logic [7:0] rand_cfg [NUM_REGS];
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'd0;
    s_tuser   = MODE_BYTE;
    cfg_valid = 1'b0;
    cfg_index = REG_ACK;
    cfg_data  = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].pinned,
                dir_rows[i].cmd, dir_rows[i].status, dir_rows[i].recv);
    end
    drain();

    program_regs(REG_RESET);
    run_random(12, 1'b1);
    drain();

    program_regs(CFG_CORNER_A);
    run_random(8, 1'b0);
    drain();

    program_regs(CFG_CORNER_B);
    run_random(8, 1'b0);
    drain();

    foreach (rand_cfg[i]) rand_cfg[i] = 8'($urandom_range(1, 255));
    program_regs(rand_cfg);
    run_random(12, 1'b0);
    send_long_frame();
    drain();

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/sfr_pkg.sv
design/sfr_ram.sv
design/sfr_ctrl.sv
design/sfr_emit.sv
design/serial_frame_receiver.sv
verif/tb.sv
